[src/fdtt_pkg.sv]
`timescale 1ns / 1ps

package fdtt_pkg;

  // Geometry of the tracked framebuffer.
  localparam int unsigned TILE_SIZE  = 16;
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  localparam int unsigned COORD_W     = 8;
  localparam int unsigned TILE_IDX_W  = 4;
  localparam int unsigned TILE_BITS   = $clog2(TILE_SIZE);
  localparam int unsigned TILES_X     = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned TILES_Y     = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned TILE_COUNT  = TILES_X * TILES_Y;
  localparam int unsigned TILE_ADDR_W = $clog2(TILE_COUNT);
  localparam int unsigned SPAN_W      = $clog2(TILES_X + 1);

  localparam int unsigned SHADOW_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned SHADOW_ADDR_W = $clog2(SHADOW_DEPTH);

  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned VALUE_W = 32;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_MAX_W = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] SIZE_MAX_H = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    MODE_COMPARE   = 2'd0,
    MODE_MARK      = 2'd1,
    MODE_CLEAN     = 2'd2,
    MODE_RESET_ALL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_W-1:0]    pixel_x;
    logic [COORD_W-1:0]    pixel_y;
    logic [VALUE_W-1:0]    pixel_value;
    logic [TILE_IDX_W-1:0] tile_col;
    logic [TILE_IDX_W-1:0] tile_row;
  } in_req_t;

  typedef struct packed {
    logic               tile_is_dirty;
    logic               pixel_changed;
    logic [TOTAL_W-1:0] dirty_total;
    logic               out_of_range;
  } out_req_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic reset_all;
    logic out_free;
  } status_t;

  // A zero size acts as one pixel and an oversize value as the maximum.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Number of tiles that cover a span of pixels, rounded up.
  function automatic logic [SPAN_W-1:0] tile_span(input logic [SIZE_W-1:0] eff);
    logic [SIZE_W:0] sum;
    sum = {1'b0, eff} + (SIZE_W + 1)'(TILE_SIZE - 1);
    return SPAN_W'(sum >> TILE_BITS);
  endfunction

endpackage

[src/fdtt_ctrl.sv]
`timescale 1ns / 1ps

module fdtt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fdtt_pkg::status_t status_i,
  output fdtt_pkg::cmd_t    cmd_o
);

  fdtt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdtt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdtt_pkg::ST_CLEAR: begin
        if (status_i.sweep_last) begin
          state_d = fdtt_pkg::ST_IDLE;
        end
      end
      fdtt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fdtt_pkg::ST_EXEC;
        end
      end
      fdtt_pkg::ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = status_i.reset_all ? fdtt_pkg::ST_CLEAR : fdtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdtt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fdtt_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
      end
      fdtt_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      fdtt_pkg::ST_EXEC: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[src/fdtt_datapath.sv]
`timescale 1ns / 1ps

module fdtt_datapath #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdtt_pkg::cmd_t                      cmd_i,
  output fdtt_pkg::status_t                   status_o,
  input  fdtt_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fdtt_pkg::out_req_t                  out_req_o,
  input  logic                                cfg_we_i,
  input  logic [fdtt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fdtt_pkg::SIZE_W-1:0]         cfg_data_i
);

  localparam int unsigned ADDR_W  = fdtt_pkg::SHADOW_ADDR_W;
  localparam int unsigned TADDR_W = fdtt_pkg::TILE_ADDR_W;
  localparam int unsigned SPAN_W  = fdtt_pkg::SPAN_W;
  localparam int unsigned SIZE_W  = fdtt_pkg::SIZE_W;
  localparam int unsigned TOTAL_W = fdtt_pkg::TOTAL_W;
  localparam int unsigned CW      = fdtt_pkg::COORD_W;
  localparam int unsigned TB      = fdtt_pkg::TILE_BITS;
  localparam int unsigned TIW     = fdtt_pkg::TILE_IDX_W;

  // Configuration, held as effective sizes and tile spans.
  logic [SIZE_W-1:0] eff_w_q, eff_h_q;
  logic [SPAN_W-1:0] map_w_q, map_h_q;
  logic [SIZE_W-1:0] cfg_eff;

  assign cfg_eff = (cfg_index_i == fdtt_pkg::CFG_SCREEN_WIDTH) ?
                   fdtt_pkg::eff_size(cfg_data_i, fdtt_pkg::SIZE_MAX_W) :
                   fdtt_pkg::eff_size(cfg_data_i, fdtt_pkg::SIZE_MAX_H);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= fdtt_pkg::SIZE_MAX_W;
      eff_h_q <= fdtt_pkg::SIZE_MAX_H;
      map_w_q <= fdtt_pkg::tile_span(fdtt_pkg::SIZE_MAX_W);
      map_h_q <= fdtt_pkg::tile_span(fdtt_pkg::SIZE_MAX_H);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fdtt_pkg::CFG_SCREEN_WIDTH: begin
          eff_w_q <= cfg_eff;
          map_w_q <= fdtt_pkg::tile_span(cfg_eff);
        end
        fdtt_pkg::CFG_SCREEN_HEIGHT: begin
          eff_h_q <= cfg_eff;
          map_h_q <= fdtt_pkg::tile_span(cfg_eff);
        end
      endcase
    end
  end

  // Item register, loaded when a request is taken.
  fdtt_pkg::in_req_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_req_i;
    end
  end

  // Shadow framebuffer with a fixed row stride of the maximum width.
  logic [PIXEL_BITS-1:0] shadow_mem [fdtt_pkg::SHADOW_DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_q;
  logic [ADDR_W-1:0]     rd_addr, item_addr, mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     sweep_addr_q;

  assign rd_addr   = ADDR_W'({in_req_i.pixel_y, in_req_i.pixel_x});
  assign item_addr = ADDR_W'({item_q.pixel_y, item_q.pixel_x});

  // Decode of the held item.
  logic [TADDR_W-1:0] pix_tile, map_tile;
  logic               pix_in_range, tile_in_range, pix_changed;

  assign pix_tile = TADDR_W'({item_q.pixel_y[CW-1 -: CW-TB], item_q.pixel_x[CW-1 -: CW-TB]});
  assign map_tile = TADDR_W'({item_q.tile_row, item_q.tile_col});
  assign pix_in_range  = ({1'b0, item_q.pixel_x} < eff_w_q) &&
                         ({1'b0, item_q.pixel_y} < eff_h_q);
  assign tile_in_range = ({1'b0, item_q.tile_col} < map_w_q) &&
                         ({1'b0, item_q.tile_row} < map_h_q);
  assign pix_changed   = rd_data_q != item_q.pixel_value[PIXEL_BITS-1:0];

  assign mem_we    = cmd_i.sweep ||
                     (cmd_i.commit && (item_q.mode == fdtt_pkg::MODE_COMPARE) && pix_in_range);
  assign mem_waddr = cmd_i.sweep ? sweep_addr_q : item_addr;
  assign mem_wdata = cmd_i.sweep ? '0 : item_q.pixel_value[PIXEL_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_data_q <= shadow_mem[rd_addr];
    end
  end

  // The sweep address wraps back to zero at the end of each pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
    end
  end

  // Tile marks live in a small memory. Every sweep rewrites it while the sweep
  // address is below the tile count: with the tile map latched by a reset-all, or
  // with zeros after reset, when the latched map is empty.
  logic               mark_mem [fdtt_pkg::TILE_COUNT];
  logic               mark_rd_q;
  logic [TADDR_W-1:0] rd_tile, mark_addr, mark_waddr;
  logic               mark_we, mark_wdata, mark_upd, mark_val, sweep_fill;
  logic [SPAN_W-1:0]  fill_w_q, fill_h_q;
  logic [TOTAL_W-1:0] tally_q, tally_d;
  logic [2*SPAN_W-1:0] fill_count;
  fdtt_pkg::out_req_t rsp;

  assign rd_tile = (in_req_i.mode == fdtt_pkg::MODE_COMPARE) ?
                   TADDR_W'({in_req_i.pixel_y[CW-1 -: CW-TB], in_req_i.pixel_x[CW-1 -: CW-TB]}) :
                   TADDR_W'({in_req_i.tile_row, in_req_i.tile_col});
  assign mark_addr = (item_q.mode == fdtt_pkg::MODE_COMPARE) ? pix_tile : map_tile;

  assign sweep_fill = ({1'b0, sweep_addr_q[TIW-1:0]} < fill_w_q) &&
                      ({1'b0, sweep_addr_q[TADDR_W-1:TIW]} < fill_h_q);

  assign mark_we    = cmd_i.sweep ? (sweep_addr_q[ADDR_W-1:TADDR_W] == '0) :
                                    (cmd_i.commit && mark_upd);
  assign mark_waddr = cmd_i.sweep ? sweep_addr_q[TADDR_W-1:0] : mark_addr;
  assign mark_wdata = cmd_i.sweep ? sweep_fill : mark_val;

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (cmd_i.accept) begin
      mark_rd_q <= mark_mem[rd_tile];
    end
  end

  assign fill_count = {{SPAN_W{1'b0}}, map_w_q} * {{SPAN_W{1'b0}}, map_h_q};

  always_comb begin
    mark_upd = 1'b0;
    mark_val = 1'b0;
    tally_d  = tally_q;
    rsp      = '0;
    unique case (fdtt_pkg::mode_e'(item_q.mode))
      fdtt_pkg::MODE_COMPARE: begin
        if (pix_in_range) begin
          rsp.pixel_changed = pix_changed;
          rsp.tile_is_dirty = mark_rd_q | pix_changed;
          if (pix_changed && !mark_rd_q) begin
            mark_upd = 1'b1;
            mark_val = 1'b1;
            tally_d  = tally_q + TOTAL_W'(1);
          end
        end else begin
          rsp.out_of_range = 1'b1;
        end
      end
      fdtt_pkg::MODE_MARK: begin
        if (tile_in_range) begin
          rsp.tile_is_dirty = 1'b1;
          if (!mark_rd_q) begin
            mark_upd = 1'b1;
            mark_val = 1'b1;
            tally_d  = tally_q + TOTAL_W'(1);
          end
        end else begin
          rsp.out_of_range = 1'b1;
        end
      end
      fdtt_pkg::MODE_CLEAN: begin
        if (tile_in_range) begin
          if (mark_rd_q) begin
            mark_upd = 1'b1;
            mark_val = 1'b0;
            tally_d  = tally_q - TOTAL_W'(1);
          end
        end else begin
          rsp.out_of_range = 1'b1;
        end
      end
      fdtt_pkg::MODE_RESET_ALL: begin
        tally_d           = TOTAL_W'(fill_count);
        rsp.tile_is_dirty = 1'b1;
      end
    endcase
    rsp.dirty_total = tally_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q  <= '0;
      fill_w_q <= '0;
      fill_h_q <= '0;
    end else if (cmd_i.commit) begin
      tally_q <= tally_d;
      if (item_q.mode == fdtt_pkg::MODE_RESET_ALL) begin
        fill_w_q <= map_w_q;
        fill_h_q <= map_h_q;
      end
    end
  end

  // Output register.
  logic               out_valid_q;
  fdtt_pkg::out_req_t out_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_req_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  assign status_o.sweep_last = &sweep_addr_q;
  assign status_o.reset_all  = item_q.mode == fdtt_pkg::MODE_RESET_ALL;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

[src/framebuffer_dirty_tile_tracker.sv]
`timescale 1ns / 1ps

// Dirty-tile tracker for a framebuffer of up to 256 x 256 pixels in 16 x 16 tiles.
// Requests come in on in_valid_i / in_stall_o / in_req_i, one command each:
// compare a pixel against the shadow copy, mark a tile dirty, clean a tile, or
// reset all. Every request yields exactly one result on out_valid_o /
// out_stall_i / out_req_o with the tile mark, the pixel change flag, the dirty
// tile count and an out-of-range flag.
// Screen width and height are written through cfg_we_i / cfg_index_i /
// cfg_data_i (index 0 width, index 1 height) while no request is in flight.
// When a request is taken, the item and the words read from the shadow memory and
// the tile mark memory are registered (ST_IDLE to ST_EXEC). In ST_EXEC, once the
// result register is free, the result is registered and both memories are
// written. Requests are handled one at a time.
// After reset, and after every reset-all request, the shadow memory is cleared
// one word per cycle; the tile marks are rewritten at the start of that pass,
// at the sweep addresses below the tile count. in_stall_o is high during the pass.
// The reset-all result itself is delivered at the start of the pass.
// If the receiver stalls, the result register holds its value and the block
// finishes no further request until that result has been taken.
module framebuffer_dirty_tile_tracker #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fdtt_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fdtt_pkg::out_req_t             out_req_o,
  input  logic                           cfg_we_i,
  input  logic [fdtt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fdtt_pkg::SIZE_W-1:0]    cfg_data_i
);

  fdtt_pkg::cmd_t    cmd;
  fdtt_pkg::status_t status;

  fdtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdtt_datapath #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

[src/fdtt_checker.sv]
`timescale 1ns / 1ps

module fdtt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input fdtt_pkg::out_req_t             out_req_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Requests are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  // An ignored request reports a clean, unchanged pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.out_of_range |->
      !out_req_o.tile_is_dirty && !out_req_o.pixel_changed)
    else $error("out-of-range result carries marks");

  // A changed pixel always leaves its tile dirty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.pixel_changed |-> out_req_o.tile_is_dirty)
    else $error("changed pixel left tile clean");

  // The count never exceeds the number of tiles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.dirty_total <= fdtt_pkg::TOTAL_W'(fdtt_pkg::TILE_COUNT))
    else $error("dirty count above tile count");

endmodule

bind framebuffer_dirty_tile_tracker fdtt_checker u_fdtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

[tb/framebuffer_dirty_tile_tracker_test.sv]
`timescale 1ns / 1ps

module framebuffer_dirty_tile_tracker_test;
  import fdtt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_req_t out_req_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_SCREEN_WIDTH;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  framebuffer_dirty_tile_tracker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow framebuffer, tile marks and dirty count as the block should hold them.
  logic [VALUE_W-1:0] shadow_copy [0:SHADOW_DEPTH-1];
  bit tile_marked [0:TILE_COUNT-1];
  int unsigned dirty_count;
  logic [SIZE_W-1:0] screen_w_setting = SIZE_MAX_W;
  logic [SIZE_W-1:0] screen_h_setting = SIZE_MAX_H;

  in_req_t queued_commands [$];
  out_req_t due_tile_reports [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned top);
    if (v == '0) begin
      return 1;
    end
    return (v > top) ? top : int'(v);
  endfunction

  function automatic int unsigned tiles_across();
    return (clamp_size(screen_w_setting, MAX_WIDTH) + TILE_SIZE - 1) / TILE_SIZE;
  endfunction

  function automatic int unsigned tiles_down();
    return (clamp_size(screen_h_setting, MAX_HEIGHT) + TILE_SIZE - 1) / TILE_SIZE;
  endfunction

  function automatic void wipe_tracker();
    for (int i = 0; i < SHADOW_DEPTH; i++) begin
      shadow_copy[i] = '0;
    end
    for (int i = 0; i < TILE_COUNT; i++) begin
      tile_marked[i] = 1'b0;
    end
    dirty_count = 0;
  endfunction

  // Applies one request to the tracked state and queues the report it must produce.
  function automatic void predict_tile_report(input in_req_t r);
    out_req_t rep;
    int unsigned w, h, cols, rows, pi, ti;
    rep = '0;
    w = clamp_size(screen_w_setting, MAX_WIDTH);
    h = clamp_size(screen_h_setting, MAX_HEIGHT);
    cols = tiles_across();
    rows = tiles_down();
    case (r.mode)
      MODE_COMPARE: begin
        if (r.pixel_x >= w || r.pixel_y >= h) begin
          rep.out_of_range = 1'b1;
        end else begin
          pi = r.pixel_y * MAX_WIDTH + r.pixel_x;
          ti = (r.pixel_y / TILE_SIZE) * TILES_X + r.pixel_x / TILE_SIZE;
          rep.pixel_changed = (shadow_copy[pi] != r.pixel_value);
          shadow_copy[pi] = r.pixel_value;
          if (rep.pixel_changed && !tile_marked[ti]) begin
            tile_marked[ti] = 1'b1;
            dirty_count++;
          end
          rep.tile_is_dirty = tile_marked[ti];
        end
      end
      MODE_MARK, MODE_CLEAN: begin
        if (r.tile_col >= cols || r.tile_row >= rows) begin
          rep.out_of_range = 1'b1;
        end else begin
          ti = r.tile_row * TILES_X + r.tile_col;
          if (r.mode == MODE_MARK && !tile_marked[ti]) begin
            tile_marked[ti] = 1'b1;
            dirty_count++;
          end else if (r.mode == MODE_CLEAN && tile_marked[ti]) begin
            tile_marked[ti] = 1'b0;
            dirty_count--;
          end
          rep.tile_is_dirty = tile_marked[ti];
        end
      end
      default: begin
        wipe_tracker();
        for (int unsigned y = 0; y < rows; y++) begin
          for (int unsigned x = 0; x < cols; x++) begin
            tile_marked[y * TILES_X + x] = 1'b1;
          end
        end
        dirty_count = cols * rows;
        rep.tile_is_dirty = 1'b1;
      end
    endcase
    rep.dirty_total = TOTAL_W'(dirty_count);
    due_tile_reports.push_back(rep);
  endfunction

  // Fields a command does not use carry random bits.
  function automatic in_req_t scrambled_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_req_t)-1:0];
  endfunction

  function automatic void push_compare(int unsigned x, int unsigned y, logic [31:0] v);
    in_req_t r;
    r = scrambled_request();
    r.mode = MODE_COMPARE;
    r.pixel_x = COORD_W'(x);
    r.pixel_y = COORD_W'(y);
    r.pixel_value = v;
    queued_commands.push_back(r);
  endfunction

  function automatic void push_tile(mode_e m, int unsigned col, int unsigned row);
    in_req_t r;
    r = scrambled_request();
    r.mode = m;
    r.tile_col = TILE_IDX_W'(col);
    r.tile_row = TILE_IDX_W'(row);
    queued_commands.push_back(r);
  endfunction

  function automatic void push_reset_all();
    in_req_t r;
    r = scrambled_request();
    r.mode = MODE_RESET_ALL;
    queued_commands.push_back(r);
  endfunction

  task automatic queue_random_commands(input int count, input bit with_reset_all);
    int unsigned w, h, cols, rows, x, y, slot, pick;
    int unsigned recent_x [8];
    int unsigned recent_y [8];
    logic [31:0] palette [4];
    logic [31:0] v;
    int i;
    w = clamp_size(screen_w_setting, MAX_WIDTH);
    h = clamp_size(screen_h_setting, MAX_HEIGHT);
    cols = tiles_across();
    rows = tiles_down();
    palette[0] = '0;
    palette[1] = '1;
    palette[2] = $urandom;
    palette[3] = $urandom;
    for (i = 0; i < 8; i++) begin
      recent_x[i] = $urandom_range(0, w - 1);
      recent_y[i] = $urandom_range(0, h - 1);
    end
    for (i = 0; i < count; i++) begin
      if (with_reset_all && i == count / 2) begin
        push_reset_all();
        continue;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Revisiting recent pixels with a small palette makes unchanged pixels common.
        slot = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end else if ($urandom_range(0, 1) == 1) begin
          x = recent_x[slot];
          y = recent_y[slot];
        end else begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
          recent_x[slot] = x;
          recent_y[slot] = y;
        end
        v = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)] : 32'($urandom);
        push_compare(x, y, v);
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          x = $urandom_range(0, 15);
          y = $urandom_range(0, 15);
        end else begin
          x = $urandom_range(0, cols - 1);
          y = $urandom_range(0, rows - 1);
        end
        push_tile((pick < 75) ? MODE_MARK : MODE_CLEAN, x, y);
      end
    end
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= SIZE_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) begin
      screen_w_setting = SIZE_W'(value);
    end else begin
      screen_h_setting = SIZE_W'(value);
    end
  endtask

  // The check runs just after the edge, once the driver and the checker have
  // updated the queues and the request valid.
  task automatic wait_quiet();
    while (queued_commands.size() != 0 || in_valid_i || due_tile_reports.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : command_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_tile_report(in_req_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          in_req_i <= queued_commands.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            send_calm = !send_calm;
          end
          send_gap = send_calm ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : report_checker
    out_req_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_tile_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: dirty=%0b changed=%0b total=%0d oor=%0b",
                     out_req_o.tile_is_dirty, out_req_o.pixel_changed,
                     out_req_o.dirty_total, out_req_o.out_of_range);
          end
        end else begin
          want = due_tile_reports.pop_front();
          if (out_req_o.tile_is_dirty !== want.tile_is_dirty ||
              out_req_o.pixel_changed !== want.pixel_changed ||
              out_req_o.dirty_total !== want.dirty_total ||
              out_req_o.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at cycle %0d: expected dirty=%0b changed=%0b total=%0d oor=%0b,",
                       cycle_count, want.tile_is_dirty, want.pixel_changed,
                       want.dirty_total, want.out_of_range);
              $display("  got dirty=%0b changed=%0b total=%0d oor=%0b",
                       out_req_o.tile_is_dirty, out_req_o.pixel_changed,
                       out_req_o.dirty_total, out_req_o.out_of_range);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          take_calm = !take_calm;
        end
        hold_left = take_calm ? 0 : $urandom_range(0, 4);
      end else if (out_valid_o && hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("framebuffer_dirty_tile_tracker_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_w [8];
    int unsigned phase_h [8];
    phase_w = '{256, 1, 0, 511, 17, 255, 0, 16};
    phase_h = '{256, 1, 0, 300, 33, 16, 0, 255};
    phase_w[6] = $urandom_range(1, 256);
    phase_h[6] = $urandom_range(1, 256);
    wipe_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-size screen: unchanged and changed pixels, corners, mark and clean
    // of clean and dirty tiles, and a reset-all followed by a compare of zero.
    push_compare(0, 0, 32'h0);
    push_compare(0, 0, 32'hFFFF_FFFF);
    push_compare(255, 255, 32'h8000_0001);
    push_compare(0, 0, 32'hFFFF_FFFF);
    push_tile(MODE_MARK, 15, 15);
    push_tile(MODE_MARK, 0, 15);
    push_tile(MODE_CLEAN, 0, 15);
    push_tile(MODE_CLEAN, 0, 15);
    push_tile(MODE_CLEAN, 0, 0);
    push_compare(15, 15, 32'h1);
    push_reset_all();
    push_compare(0, 0, 32'h0);
    push_tile(MODE_CLEAN, 15, 15);
    push_tile(MODE_CLEAN, 3, 7);
    wait_quiet();

    // Narrow screen: addresses just past the edges, marks left outside the
    // screen still counted, and a reset-all over the smaller tile map.
    write_size(CFG_SCREEN_WIDTH, 20);
    write_size(CFG_SCREEN_HEIGHT, 40);
    push_compare(20, 0, 32'h1234_5678);
    push_compare(19, 39, 32'h1234_5678);
    push_compare(0, 40, 32'h5);
    push_tile(MODE_MARK, 2, 0);
    push_tile(MODE_MARK, 1, 2);
    push_tile(MODE_CLEAN, 0, 3);
    push_tile(MODE_CLEAN, 1, 2);
    push_reset_all();
    push_compare(19, 39, 32'h0);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      write_size(CFG_SCREEN_WIDTH, phase_w[p]);
      write_size(CFG_SCREEN_HEIGHT, phase_h[p]);
      queue_random_commands(245, (p == 1 || p == 3 || p == 6));
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && due_tile_reports.size() == 0) begin
      $display("framebuffer_dirty_tile_tracker_test: done, clean");
    end else begin
      $display("framebuffer_dirty_tile_tracker_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/fdtt_pkg.sv
src/fdtt_ctrl.sv
src/fdtt_datapath.sv
src/framebuffer_dirty_tile_tracker.sv
src/fdtt_checker.sv
tb/framebuffer_dirty_tile_tracker_test.sv
